@@ hdl/r16s_pkg.sv @@
// Shared types and constants for the 16-bit eight-instruction step unit.
// Used by r16s_alu and risc16_instruction_step_unit; no dependencies.
package r16s_pkg;

  // word memory size; a power of two, addresses wrap by dropping upper bits
  localparam int MEM_WORDS = 65536;

  // item actions
  localparam logic [1:0] ACT_STEP  = 2'd0;
  localparam logic [1:0] ACT_POKE  = 2'd1;
  localparam logic [1:0] ACT_SETPC = 2'd2;

  // opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_ADDI = 3'd1;
  localparam logic [2:0] OP_NAND = 3'd2;
  localparam logic [2:0] OP_LUI  = 3'd3;
  localparam logic [2:0] OP_SW   = 3'd4;
  localparam logic [2:0] OP_LW   = 3'd5;
  localparam logic [2:0] OP_BEQ  = 3'd6;
  localparam logic [2:0] OP_JALR = 3'd7;

  // configuration register indexes
  localparam logic [7:0] CFG_RAM_START = 8'd0;
  localparam logic [7:0] CFG_RAM_END   = 8'd1;

  localparam logic [15:0] RAM_START_RST = 16'h8000;
  localparam logic [15:0] RAM_END_RST   = 16'hffff;

  // instruction field masks
  localparam logic [15:0] UPPER10 = 16'hffc0;
  localparam logic [15:0] IMM7    = 16'h007f;
  localparam logic [15:0] IMM10   = 16'h03ff;

  typedef struct packed {
    logic        reg_wr;    // nonzero rA written
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;   // zero for a load, data comes from memory
    logic        is_load;
    logic [15:0] ld_addr;
    logic        st_wr;     // store inside the window
    logic [15:0] st_addr;   // before wrap
    logic [15:0] st_val;
    logic [15:0] next_pc;
  } alu_res_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] executed_word;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
  } result_t;

endpackage

@@ hdl/risc16_instruction_step_unit.sv @@
// Top level of the 16-bit eight-instruction step unit.
// Depends on r16s_pkg, r16s_wmem, r16s_rfile and r16s_alu.
//
// Input channel (in_valid / in_stall): one item per transfer. action 0 runs
// one instruction at the program counter, 1 pokes poke_value into the word
// at target_address, 2 loads the program counter from target_address.
// Output channel (out_valid / out_stall): one result per item, in order.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 writes the
// lowest store address, index 1 the exclusive upper bound; other indexes
// are dropped. Write it only while the unit is idle.
// Sequence: a step goes from transfer to result through fetch read,
// register file read and execute, a load adds a second word memory read;
// poke and set-pc go straight to execute. The next item is taken in the
// cycle the previous one finishes, so items do not overlap, paced by the
// sequence of synchronous reads of the word memory and the register file.
// A result waits in the output register while out_stall is high; the unit
// holds the next item in execute or load until that register frees.
// Reset clears the pc and registers and sets the window bounds to their
// reset values; memory stays undefined until poked. Addresses wrap at MEM_WORDS.
module risc16_instruction_step_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] target_address,
  input  logic [15:0] poke_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] next_pc,
  output logic [15:0] executed_word,
  output logic        reg_written,
  output logic [2:0]  reg_index,
  output logic [15:0] reg_value,
  output logic        mem_written,
  output logic [15:0] mem_address,
  output logic [15:0] mem_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(r16s_pkg::MEM_WORDS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [1:0]  act;
  logic [15:0] taddr;
  logic [15:0] pval;
  logic [15:0] pc;
  logic [15:0] ir;
  logic [15:0] win_start;
  logic [15:0] win_end;

  logic [15:0] mem_rdata;
  logic        mem_re;
  logic [AW-1:0] mem_raddr;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0] mem_wdata;

  logic        rf_re;
  logic [2:0]  rf_raddr_b;
  logic [15:0] rf_rdata_a;
  logic [15:0] rf_rdata_b;
  logic        rf_we;

  r16s_pkg::alu_res_t alu;
  r16s_pkg::result_t  fin;
  r16s_pkg::result_t  res_q;

  logic        in_acc;
  logic        step_load;
  logic        out_free;
  logic        fire;
  logic [2:0]  start_state;
  logic [2:0]  dec_op;

  assign in_acc      = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign step_load   = (act == r16s_pkg::ACT_STEP) && alu.is_load;
  assign fire        = out_free && ((state == S_EXEC && !step_load) || state == S_LOAD);
  assign in_stall    = !((state == S_IDLE) || fire);
  assign start_state = (action == r16s_pkg::ACT_STEP) ? S_FETCH : S_EXEC;
  assign cfg_ready   = 1'b1;

  // register reads are issued while the fetched word is on the memory output
  assign dec_op     = mem_rdata[15:13];
  assign rf_re      = (state == S_DEC);
  assign rf_raddr_b = (dec_op == r16s_pkg::OP_SW || dec_op == r16s_pkg::OP_BEQ) ?
                      mem_rdata[12:10] : mem_rdata[2:0];

  r16s_rfile u_rfile (
    .clk     (clk),
    .rst     (rst),
    .we      (rf_we),
    .waddr   (fin.reg_index),
    .wdata   (fin.reg_value),
    .re      (rf_re),
    .raddr_a (mem_rdata[9:7]),
    .raddr_b (rf_raddr_b),
    .rdata_a (rf_rdata_a),
    .rdata_b (rf_rdata_b)
  );

  r16s_alu u_alu (
    .word      (ir),
    .pc        (pc),
    .rb_val    (rf_rdata_a),
    .rx_val    (rf_rdata_b),
    .win_start (win_start),
    .win_end   (win_end),
    .res       (alu)
  );

  assign mem_re    = (state == S_FETCH) || (state == S_EXEC && step_load);
  assign mem_raddr = (state == S_FETCH) ? pc[AW-1:0] : alu.ld_addr[AW-1:0];

  r16s_wmem #(
    .DEPTH (r16s_pkg::MEM_WORDS),
    .AW    (AW)
  ) u_wmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    fin         = '0;
    fin.next_pc = pc;
    case (act)
      r16s_pkg::ACT_STEP: begin
        fin.next_pc       = alu.next_pc;
        fin.executed_word = ir;
        fin.reg_written   = alu.reg_wr;
        fin.reg_index     = alu.reg_idx;
        fin.reg_value     = (alu.is_load && alu.reg_wr) ? mem_rdata : alu.reg_val;
        fin.mem_written   = alu.st_wr;
        fin.mem_address   = alu.st_wr ? 16'(alu.st_addr[AW-1:0]) : 16'd0;
        fin.mem_value     = alu.st_val;
      end
      r16s_pkg::ACT_POKE: begin
        fin.mem_written = 1'b1;
        fin.mem_address = 16'(taddr[AW-1:0]);
        fin.mem_value   = pval;
      end
      r16s_pkg::ACT_SETPC: begin
        fin.next_pc = taddr;
      end
      default: begin
        fin.next_pc = pc;
      end
    endcase
  end

  assign mem_we    = fire && (state == S_EXEC) && fin.mem_written;
  assign mem_waddr = fin.mem_address[AW-1:0];
  assign mem_wdata = fin.mem_value;
  assign rf_we     = fire && fin.reg_written;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = start_state;
        end
      end
      S_FETCH: state_next = S_DEC;
      S_DEC:   state_next = S_EXEC;
      S_EXEC: begin
        if (step_load) begin
          state_next = S_LOAD;
        end else if (fire) begin
          state_next = in_acc ? start_state : S_IDLE;
        end
      end
      S_LOAD: begin
        if (fire) begin
          state_next = in_acc ? start_state : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= 16'd0;
      out_valid <= 1'b0;
      win_start <= r16s_pkg::RAM_START_RST;
      win_end   <= r16s_pkg::RAM_END_RST;
    end else begin
      state <= state_next;
      if (fire) begin
        pc        <= fin.next_pc;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == r16s_pkg::CFG_RAM_START) begin
          win_start <= cfg_data;
        end else if (cfg_index == r16s_pkg::CFG_RAM_END) begin
          win_end <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act   <= action;
      taddr <= target_address;
      pval  <= poke_value;
    end
    if (state == S_DEC) begin
      ir <= mem_rdata;
    end
    if (fire) begin
      res_q <= fin;
    end
  end

  assign next_pc       = res_q.next_pc;
  assign executed_word = res_q.executed_word;
  assign reg_written   = res_q.reg_written;
  assign reg_index     = res_q.reg_index;
  assign reg_value     = res_q.reg_value;
  assign mem_written   = res_q.mem_written;
  assign mem_address   = res_q.mem_address;
  assign mem_value     = res_q.mem_value;

endmodule

@@ hdl/r16s_wmem.sv @@
// Word memory: one write port, one registered read port.
// No package dependency; contents undefined until written.
module r16s_wmem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/r16s_rfile.sv @@
// Register file: 8 x 16 memory, one write and two registered read ports.
// Per-entry valid bits make unwritten registers (and r0) read as zero.
module r16s_rfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        we,
  input  logic [2:0]  waddr,
  input  logic [15:0] wdata,
  input  logic        re,
  input  logic [2:0]  raddr_a,
  input  logic [2:0]  raddr_b,
  output logic [15:0] rdata_a,
  output logic [15:0] rdata_b
);

  logic [15:0] mem [8];
  logic [7:0]  valid;
  logic [15:0] data_a;
  logic [15:0] data_b;
  logic        vld_a;
  logic        vld_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (we && waddr != 3'd0) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        vld_a <= valid[raddr_a];
        vld_b <= valid[raddr_b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      data_a <= mem[raddr_a];
      data_b <= mem[raddr_b];
    end
  end

  assign rdata_a = vld_a ? data_a : 16'd0;
  assign rdata_b = vld_b ? data_b : 16'd0;

endmodule

@@ hdl/r16s_alu.sv @@
// Decode and execute of one instruction word.
// Uses r16s_pkg for opcodes, masks and the alu_res_t result struct.
module r16s_alu (
  input  logic              [15:0] word,
  input  logic              [15:0] pc,
  input  logic              [15:0] rb_val,
  input  logic              [15:0] rx_val,   // rC, or rA for sw and beq
  input  logic              [15:0] win_start,
  input  logic              [15:0] win_end,
  output r16s_pkg::alu_res_t       res
);

  logic [2:0]  op;
  logic [2:0]  ra;
  logic [15:0] imm7;
  logic [15:0] pc1;
  logic [15:0] addr;
  logic        wr;
  logic [15:0] wv;

  assign op   = word[15:13];
  assign ra   = word[12:10];
  assign imm7 = word & r16s_pkg::IMM7;
  assign pc1  = pc + 16'd1;
  assign addr = imm7 + rb_val;

  always_comb begin
    wr           = 1'b0;
    wv           = 16'd0;
    res          = '0;
    res.next_pc  = pc1;
    case (op)
      r16s_pkg::OP_ADD: begin
        wr = 1'b1;
        wv = rb_val + rx_val;
      end
      r16s_pkg::OP_ADDI: begin
        wr = 1'b1;
        wv = rb_val + imm7;
      end
      r16s_pkg::OP_NAND: begin
        wr = 1'b1;
        wv = ~(rb_val & rx_val);
      end
      r16s_pkg::OP_LUI: begin
        wr = 1'b1;
        wv = {word[9:0], 6'd0} & r16s_pkg::UPPER10;
      end
      r16s_pkg::OP_SW: begin
        if (addr >= win_start && addr < win_end) begin
          res.st_wr   = 1'b1;
          res.st_addr = addr;
          res.st_val  = rx_val;
        end
      end
      r16s_pkg::OP_LW: begin
        wr          = 1'b1;
        res.is_load = 1'b1;
        res.ld_addr = addr;
      end
      r16s_pkg::OP_BEQ: begin
        if (rx_val == rb_val) begin
          res.next_pc = (pc1 + imm7) & r16s_pkg::IMM7;
        end
      end
      default: begin
        // jalr
        wr          = 1'b1;
        wv          = pc1;
        res.next_pc = rb_val;
      end
    endcase
    if (wr && ra != 3'd0) begin
      res.reg_wr  = 1'b1;
      res.reg_idx = ra;
      res.reg_val = res.is_load ? 16'd0 : wv;
    end
  end

endmodule

@@ hdl/r16s_checker.sv @@
// Port-level checks for the step unit, attached to the top level by bind.
// No package dependency.
module r16s_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] next_pc,
  input logic        reg_written,
  input logic [2:0]  reg_index,
  input logic [15:0] reg_value,
  input logic        mem_written,
  input logic [15:0] mem_address,
  input logic [15:0] mem_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(reg_value))
    else $error("stalled result changed");

  a_no_out_after_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_reg_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reg_written ? (reg_index != 3'd0) :
                   (reg_index == 3'd0 && reg_value == 16'd0)))
    else $error("register write fields inconsistent");

  a_mem_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mem_written |-> mem_address == 16'd0 && mem_value == 16'd0)
    else $error("memory write fields set without a write");

  // the unit comes out of reset idle and open for a transfer
  a_in_open_after_rst: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind risc16_instruction_step_unit r16s_checker u_r16s_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .next_pc     (next_pc),
  .reg_written (reg_written),
  .reg_index   (reg_index),
  .reg_value   (reg_value),
  .mem_written (mem_written),
  .mem_address (mem_address),
  .mem_value   (mem_value)
);

@@ test/risc16_instruction_step_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for risc16_instruction_step_unit: short programs are poked and stepped
// against a shadow processor kept in a small class. Depends on r16s_pkg and the unit itself.
module risc16_instruction_step_unit_test;

  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] ACT_NONE = 2'd3;     // undefined action, leaves state alone
  localparam logic [7:0] CFG_UNUSED = 8'd5;   // index past the register list

  // Shadow of the processor state; predicts one outcome per transfer.
  class step_shadow;
    logic [15:0] win_lo = r16s_pkg::RAM_START_RST;
    logic [15:0] win_hi = r16s_pkg::RAM_END_RST;
    logic [15:0] pc = '0;
    logic [15:0] regs [8];
    logic [15:0] mem [int];
    r16s_pkg::result_t outcomes [$];
    int errors, n_items, n_steps, n_pokes, n_stores, n_loads, n_taken;

    function new();
      foreach (regs[i]) regs[i] = '0;
    endfunction

    function int wrap(logic [15:0] a);
      return int'(a) % r16s_pkg::MEM_WORDS;
    endfunction

    function bit written(logic [15:0] a);
      return mem.exists(wrap(a));
    endfunction

    // address the instruction at pc would load from, -1 when it is not a load
    function int load_addr_at_pc();
      logic [15:0] w, a;
      if (!written(pc)) return -1;
      w = mem[wrap(pc)];
      if (w[15:13] != r16s_pkg::OP_LW) return -1;
      a = (w & r16s_pkg::IMM7) + regs[w[9:7]];
      return int'(a);
    endfunction

    function void set_window(logic [7:0] idx, logic [15:0] data);
      if (idx == r16s_pkg::CFG_RAM_START) win_lo = data;
      else if (idx == r16s_pkg::CFG_RAM_END) win_hi = data;
    endfunction

    function void apply_item(logic [1:0] act, logic [15:0] taddr, logic [15:0] pval);
      r16s_pkg::result_t r;
      logic [15:0] w, pc1, nxt, a, wv, imm7, imm10;
      logic [2:0] op, ra, rb, rc;
      bit wr;
      r = '0;
      w = '0;
      wr = 0;
      wv = '0;
      case (act)
        r16s_pkg::ACT_POKE: begin
          mem[wrap(taddr)] = pval;
          r.mem_written = 1'b1;
          r.mem_address = 16'(wrap(taddr));
          r.mem_value = pval;
          n_pokes++;
        end
        r16s_pkg::ACT_SETPC: pc = taddr;
        r16s_pkg::ACT_STEP: begin
          n_steps++;
          w = written(pc) ? mem[wrap(pc)] : '0;
          op = w[15:13];
          ra = w[12:10];
          rb = w[9:7];
          rc = w[2:0];
          imm7 = w & r16s_pkg::IMM7;
          imm10 = w & r16s_pkg::IMM10;
          pc1 = pc + 16'd1;
          nxt = pc1;
          a = imm7 + regs[rb];
          case (op)
            r16s_pkg::OP_ADD: begin
              wr = 1;
              wv = regs[rb] + regs[rc];
            end
            r16s_pkg::OP_ADDI: begin
              wr = 1;
              wv = regs[rb] + imm7;
            end
            r16s_pkg::OP_NAND: begin
              wr = 1;
              wv = ~(regs[rb] & regs[rc]);
            end
            r16s_pkg::OP_LUI: begin
              wr = 1;
              wv = (imm10 << 6) & r16s_pkg::UPPER10;
            end
            r16s_pkg::OP_SW: begin
              if (a >= win_lo && a < win_hi) begin
                mem[wrap(a)] = regs[ra];
                r.mem_written = 1'b1;
                r.mem_address = 16'(wrap(a));
                r.mem_value = regs[ra];
                n_stores++;
              end
            end
            r16s_pkg::OP_LW: begin
              wr = 1;
              wv = written(a) ? mem[wrap(a)] : '0;
              n_loads++;
            end
            r16s_pkg::OP_BEQ: begin
              if (regs[ra] == regs[rb]) begin
                nxt = (pc1 + imm7) & r16s_pkg::IMM7;
                n_taken++;
              end
            end
            r16s_pkg::OP_JALR: begin
              // target read before the link write
              nxt = regs[rb];
              wr = 1;
              wv = pc1;
            end
            default: ;
          endcase
          if (wr && ra != 3'd0) begin
            regs[ra] = wv;
            r.reg_written = 1'b1;
            r.reg_index = ra;
            r.reg_value = wv;
          end
          pc = nxt;
          r.executed_word = w;
        end
        default: ;
      endcase
      if (act != ACT_NONE) n_items++;
      r.next_pc = pc;
      outcomes.insert(outcomes.size(), r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(r16s_pkg::result_t got);
      r16s_pkg::result_t want;
      if (outcomes.size() == 0) begin
        $error("unexpected result, next_pc %h", got.next_pc);
        errors++;
        return;
      end
      want = outcomes.pop_front();
      check_field("next_pc", want.next_pc, got.next_pc);
      check_field("executed_word", want.executed_word, got.executed_word);
      check_field("reg_written", 16'(want.reg_written), 16'(got.reg_written));
      check_field("reg_index", 16'(want.reg_index), 16'(got.reg_index));
      check_field("reg_value", want.reg_value, got.reg_value);
      check_field("mem_written", 16'(want.mem_written), 16'(got.mem_written));
      check_field("mem_address", want.mem_address, got.mem_address);
      check_field("mem_value", want.mem_value, got.mem_value);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [15:0] target_address;
  logic [15:0] poke_value;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] next_pc;
  logic [15:0] executed_word;
  logic        reg_written;
  logic [2:0]  reg_index;
  logic [15:0] reg_value;
  logic        mem_written;
  logic [15:0] mem_address;
  logic [15:0] mem_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  step_shadow tracker = new();

  risc16_instruction_step_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .target_address(target_address), .poke_value(poke_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_pc(next_pc), .executed_word(executed_word),
    .reg_written(reg_written), .reg_index(reg_index), .reg_value(reg_value),
    .mem_written(mem_written), .mem_address(mem_address), .mem_value(mem_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side over this stretch of items
  function bit calm();
    return tracker.n_items >= 500 && tracker.n_items < 700;
  endfunction

  function automatic logic [15:0] instr(logic [2:0] op, logic [2:0] ra, logic [2:0] rb,
                                        logic [6:0] low);
    return {op, ra, rb, low};
  endfunction

  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    w = 16'($urandom);
    // rA == rB makes branches taken and doubles operands
    if ($urandom_range(0, 3) == 0) w[9:7] = w[12:10];
    return w;
  endfunction

  task automatic send_item(logic [1:0] act, logic [15:0] taddr, logic [15:0] pval);
    @(negedge clk);
    while (!calm() && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    target_address <= taddr;
    poke_value <= pval;
    do @(posedge clk); while (in_stall);
    tracker.apply_item(act, taddr, pval);
  endtask

  // make sure the fetch and any load only touch written words, then step
  task automatic run_step();
    int la;
    if (!tracker.written(tracker.pc)) send_item(r16s_pkg::ACT_POKE, tracker.pc, rand_instr());
    la = tracker.load_addr_at_pc();
    if (la >= 0 && !tracker.written(16'(la)))
      send_item(r16s_pkg::ACT_POKE, 16'(la), 16'($urandom));
    send_item(r16s_pkg::ACT_STEP, 16'($urandom), 16'($urandom));
  endtask

  task automatic run_program();
    logic [15:0] base;
    int len, steps;
    base = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 120)) : 16'($urandom);
    len = $urandom_range(3, 12);
    steps = $urandom_range(len, 3 * len);
    for (int i = 0; i < len; i++) send_item(r16s_pkg::ACT_POKE, base + 16'(i), rand_instr());
    send_item(r16s_pkg::ACT_SETPC, base, 16'($urandom));
    repeat (steps) run_step();
  endtask

  task automatic random_phase(int count);
    int stop_at, pick;
    stop_at = tracker.n_items + count;
    while (tracker.n_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) run_program();
      else if (pick < 88) send_item(r16s_pkg::ACT_POKE, 16'($urandom), 16'($urandom));
      else if (pick < 95) send_item(r16s_pkg::ACT_SETPC, 16'($urandom), 16'($urandom));
      else send_item(ACT_NONE, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [7:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_window(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst = 1'b1;
    in_valid = 1'b0;
    action = r16s_pkg::ACT_STEP;
    target_address = '0;
    poke_value = '0;
    cfg_valid = 1'b0;
    cfg_index = r16s_pkg::CFG_RAM_START;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // pc wrap at the top of memory, then a fixed program touching every opcode
    send_item(r16s_pkg::ACT_SETPC, 16'hffff, 16'h0000);
    send_item(r16s_pkg::ACT_POKE, 16'hffff, instr(r16s_pkg::OP_LUI, 3'd7, 3'd7, 7'h7f));
    run_step();
    send_item(r16s_pkg::ACT_POKE, 16'd0, instr(r16s_pkg::OP_ADDI, 3'd1, 3'd0, 7'h7f));
    send_item(r16s_pkg::ACT_POKE, 16'd1, instr(r16s_pkg::OP_ADD, 3'd2, 3'd7, 7'd1));
    send_item(r16s_pkg::ACT_POKE, 16'd2, instr(r16s_pkg::OP_NAND, 3'd4, 3'd2, 7'd2));
    // lands on the end bound
    send_item(r16s_pkg::ACT_POKE, 16'd3, instr(r16s_pkg::OP_SW, 3'd2, 3'd7, 7'h3f));
    send_item(r16s_pkg::ACT_POKE, 16'd4, instr(r16s_pkg::OP_SW, 3'd2, 3'd7, 7'h00));
    send_item(r16s_pkg::ACT_POKE, 16'd5, instr(r16s_pkg::OP_LW, 3'd5, 3'd7, 7'h00));
    // load to r0 is dropped
    send_item(r16s_pkg::ACT_POKE, 16'd6, instr(r16s_pkg::OP_LW, 3'd0, 3'd7, 7'h00));
    // not taken
    send_item(r16s_pkg::ACT_POKE, 16'd7, instr(r16s_pkg::OP_BEQ, 3'd1, 3'd0, 7'd5));
    // not taken either, r4 is nonzero; taken it would go to 10
    send_item(r16s_pkg::ACT_POKE, 16'd8, instr(r16s_pkg::OP_BEQ, 3'd4, 3'd0, 7'd1));
    // jump to 0x7f
    send_item(r16s_pkg::ACT_POKE, 16'd10, instr(r16s_pkg::OP_JALR, 3'd6, 3'd1, 7'd0));
    send_item(r16s_pkg::ACT_POKE, 16'h007f, instr(r16s_pkg::OP_NAND, 3'd0, 3'd0, 7'd0));
    send_item(ACT_NONE, 16'hffff, 16'hffff);
    repeat (11) run_step();

    random_phase(170);
    drain_and_settle();
    write_window(r16s_pkg::CFG_RAM_START, 16'h0000);
    write_window(r16s_pkg::CFG_RAM_END, 16'hffff);
    random_phase(170);
    drain_and_settle();
    write_window(r16s_pkg::CFG_RAM_START, 16'hffff);    // empty window
    random_phase(170);
    drain_and_settle();
    write_window(r16s_pkg::CFG_RAM_START, 16'h4000);
    write_window(r16s_pkg::CFG_RAM_END, 16'hc000);
    write_window(CFG_UNUSED, 16'h0000);
    random_phase(170);
    drain_and_settle();
    write_window(r16s_pkg::CFG_RAM_START, 16'hc000);    // inverted, nothing stored
    write_window(r16s_pkg::CFG_RAM_END, 16'h4000);
    random_phase(150);
    drain_and_settle();
    write_window(r16s_pkg::CFG_RAM_START, 16'h0000);
    write_window(r16s_pkg::CFG_RAM_END, 16'h0000);
    random_phase(150);
    drain_and_settle();

    $display("%0d items: %0d steps, %0d pokes, %0d stores, %0d loads, %0d taken branches",
             tracker.n_items, tracker.n_steps, tracker.n_pokes, tracker.n_stores,
             tracker.n_loads, tracker.n_taken);
    $display("six store windows incl. empty and inverted; %0d mismatches", tracker.errors);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_sink
    bit held;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      // one long hold-off so the unit backs up into its input
      if (!held && tracker.n_items >= 300) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
      end
      out_stall <= !calm() && ($urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result(r16s_pkg::result_t'({next_pc, executed_word, reg_written,
                                                reg_index, reg_value, mem_written,
                                                mem_address, mem_value}));
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
